// ----- src/rprle_pkg.sv -----
package rprle_pkg;

  localparam int HDR_BYTES = 22;
  localparam logic [4:0] HDR_LAST_POS = 5'(HDR_BYTES - 1);

  localparam logic [15:0] CODE_A = 16'hBA0F;
  localparam logic [15:0] CODE_B = 16'hBA07;

  localparam logic [9:0]  MAX_ROWS_RST      = 10'd464;
  localparam logic [10:0] MAX_ROW_BYTES_RST = 11'd920;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW_BYTES = 2'd1;

  localparam logic [2:0] KIND_WORD    = 3'd0;
  localparam logic [2:0] KIND_LEVEL   = 3'd1;
  localparam logic [2:0] KIND_ROW_END = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CODE = 3'd1;
  localparam logic [2:0] ERR_BAD_ROWS = 3'd2;
  localparam logic [2:0] ERR_BAD_LEN  = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  word_index;
    logic [21:0] value;
    logic [3:0]  level;
    logic [9:0]  row;
    logic [14:0] bin;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ROWLEN,
    PH_ROWDATA
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_HDR,
    CMD_HDR_ERR,
    CMD_LEN,
    CMD_DATA,
    CMD_LEVEL,
    CMD_ROWEND,
    CMD_DONE
  } cmd_op_t;

  typedef struct packed {
    logic    capture;
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic   first;
    phase_t phase;
    logic   pos_odd;
    logic   hdr_final;
    logic   hdr_err;
    logic   run_zero;
    logic   run_last;
    logic   row_last_byte;
    logic   row_done;
    logic   last_row;
    logic   slot_free;
  } dp_status_t;

endpackage

// ----- src/rprle_dp.sv -----
module rprle_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rprle_pkg::in_item_t             in_data,
  input  rprle_pkg::dp_cmd_t              cmd,
  output rprle_pkg::dp_status_t           status,
  input  logic                            cfg_valid,
  input  logic [rprle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rprle_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rprle_pkg::out_item_t            out_data
);
  import rprle_pkg::*;

  logic [7:0]  b_r;
  logic        first_r;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  wa_r, wa_nxt;
  logic [9:0]  rows_total_r, rows_total_nxt;
  logic [9:0]  row_index_r, row_index_nxt;
  logic [10:0] rbl_r, rbl_nxt;
  logic [14:0] bin_r, bin_nxt;
  logic [21:0] bytes_r, bytes_nxt;
  logic        code_bad_r, code_bad_nxt;
  logic [3:0]  run_r, run_nxt;
  logic [9:0]  max_rows_r;
  logic [10:0] max_row_bytes_r;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] word;
  logic [3:0]  widx;
  logic        len_bad;
  logic        hdr_err;
  logic [9:0]  row_next;
  logic [21:0] bytes_inc;
  logic        slot_free;
  logic        emit;

  assign word      = {wa_r, b_r};
  assign widx      = pos_r[4:1];
  assign len_bad   = (word < 16'd2) || (word > {5'd0, max_row_bytes_r}) || word[0];
  assign hdr_err   = code_bad_r || (rows_total_r == 10'd0);
  assign row_next  = row_index_r + 10'd1;
  assign bytes_inc = bytes_r + 22'd1;
  assign slot_free = !out_valid_r || out_ready;

  assign status.first         = first_r;
  assign status.phase         = phase_r;
  assign status.pos_odd       = pos_r[0];
  assign status.hdr_final     = (pos_r == HDR_LAST_POS);
  assign status.hdr_err       = hdr_err;
  assign status.run_zero      = (b_r[7:4] == 4'd0);
  assign status.run_last      = (run_r == 4'd1);
  assign status.row_last_byte = (rbl_r == 11'd1);
  assign status.row_done      = (rbl_r == 11'd0);
  assign status.last_row      = (row_next == rows_total_r);
  assign status.slot_free     = slot_free;

  // result built from the current command
  always_comb begin
    emit    = 1'b0;
    out_nxt = '0;
    case (cmd.op)
      CMD_START: begin
        emit               = (phase_r != PH_IDLE);
        out_nxt.kind       = KIND_ERROR;
        out_nxt.value      = bytes_r;
        out_nxt.row        = row_index_r;
        out_nxt.error_code = ERR_TRUNC;
        out_nxt.last       = 1'b1;
      end
      CMD_HDR: begin
        emit               = pos_r[0];
        out_nxt.kind       = KIND_WORD;
        out_nxt.word_index = widx;
        out_nxt.value      = {6'd0, word};
        out_nxt.last       = !((pos_r == HDR_LAST_POS) && hdr_err);
      end
      CMD_HDR_ERR: begin
        emit               = 1'b1;
        out_nxt.kind       = KIND_ERROR;
        out_nxt.value      = bytes_r;
        out_nxt.row        = row_index_r;
        out_nxt.error_code = code_bad_r ? ERR_BAD_CODE : ERR_BAD_ROWS;
        out_nxt.last       = 1'b1;
      end
      CMD_LEN: begin
        emit               = pos_r[0] && len_bad;
        out_nxt.kind       = KIND_ERROR;
        out_nxt.value      = bytes_inc;
        out_nxt.row        = row_index_r;
        out_nxt.error_code = ERR_BAD_LEN;
        out_nxt.last       = 1'b1;
      end
      CMD_LEVEL: begin
        emit          = 1'b1;
        out_nxt.kind  = KIND_LEVEL;
        out_nxt.level = b_r[3:0];
        out_nxt.row   = row_index_r;
        out_nxt.bin   = bin_r;
        out_nxt.last  = (run_r == 4'd1) && (rbl_r != 11'd0);
      end
      CMD_ROWEND: begin
        emit          = 1'b1;
        out_nxt.kind  = KIND_ROW_END;
        out_nxt.value = {7'd0, bin_r};
        out_nxt.row   = row_index_r;
        out_nxt.last  = (row_next != rows_total_r);
      end
      CMD_DONE: begin
        emit          = 1'b1;
        out_nxt.kind  = KIND_DONE;
        out_nxt.value = bytes_r;
        out_nxt.last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    wa_nxt         = wa_r;
    rows_total_nxt = rows_total_r;
    row_index_nxt  = row_index_r;
    rbl_nxt        = rbl_r;
    bin_nxt        = bin_r;
    bytes_nxt      = bytes_r;
    code_bad_nxt   = code_bad_r;
    run_nxt        = run_r;
    case (cmd.op)
      CMD_START: begin
        // new packet: first byte is the high half of the code word
        phase_nxt      = PH_HEADER;
        pos_nxt        = 5'd1;
        wa_nxt         = b_r;
        rows_total_nxt = '0;
        row_index_nxt  = '0;
        rbl_nxt        = '0;
        bin_nxt        = '0;
        bytes_nxt      = 22'd1;
        code_bad_nxt   = 1'b0;
      end
      CMD_HDR: begin
        bytes_nxt = bytes_inc;
        if (!pos_r[0]) begin
          wa_nxt  = b_r;
          pos_nxt = pos_r + 5'd1;
        end else begin
          if (widx == 4'd0) begin
            code_bad_nxt = (word != CODE_A) && (word != CODE_B);
          end
          if (widx == 4'd9) begin
            rows_total_nxt = ((word >= 16'd1) && (word <= {6'd0, max_rows_r})) ?
                             word[9:0] : 10'd0;
          end
          if (pos_r == HDR_LAST_POS) begin
            pos_nxt   = '0;
            phase_nxt = hdr_err ? PH_IDLE : PH_ROWLEN;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
      end
      CMD_LEN: begin
        bytes_nxt = bytes_inc;
        if (!pos_r[0]) begin
          wa_nxt  = b_r;
          pos_nxt = 5'd1;
        end else begin
          pos_nxt = '0;
          if (len_bad) begin
            phase_nxt = PH_IDLE;
          end else begin
            rbl_nxt   = word[10:0];
            bin_nxt   = '0;
            phase_nxt = PH_ROWDATA;
          end
        end
      end
      CMD_DATA: begin
        bytes_nxt = bytes_inc;
        rbl_nxt   = rbl_r - 11'd1;
        run_nxt   = b_r[7:4];
      end
      CMD_LEVEL: begin
        bin_nxt = bin_r + 15'd1;
        run_nxt = run_r - 4'd1;
      end
      CMD_ROWEND: begin
        row_index_nxt = row_next;
        bin_nxt       = '0;
        if (row_next != rows_total_r) begin
          phase_nxt = PH_ROWLEN;
          pos_nxt   = '0;
        end
      end
      CMD_DONE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      out_valid_r     <= 1'b0;
      max_rows_r      <= MAX_ROWS_RST;
      max_row_bytes_r <= MAX_ROW_BYTES_RST;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_MAX_ROWS) begin
          max_rows_r <= cfg_data[9:0];
        end else if (cfg_index == CFG_MAX_ROW_BYTES) begin
          max_row_bytes_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_r     <= in_data.data_byte;
      first_r <= in_data.first;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
    pos_r        <= pos_nxt;
    wa_r         <= wa_nxt;
    rows_total_r <= rows_total_nxt;
    row_index_r  <= row_index_nxt;
    rbl_r        <= rbl_nxt;
    bin_r        <= bin_nxt;
    bytes_r      <= bytes_nxt;
    code_bad_r   <= code_bad_nxt;
    run_r        <= run_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/rprle_ctrl.sv -----
module rprle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rprle_pkg::dp_status_t status,
  output rprle_pkg::dp_cmd_t    cmd
);
  import rprle_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DECODE,
    C_HDR_ERR,
    C_LEVEL,
    C_ROWEND,
    C_DONE
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_ready = (state_r == C_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = CMD_NONE;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = C_DECODE;
        end
      end
      C_DECODE: begin
        if (status.slot_free) begin
          state_nxt = C_IDLE;
          if (status.first) begin
            cmd.op = CMD_START;
          end else begin
            case (status.phase)
              PH_HEADER: begin
                cmd.op = CMD_HDR;
                if (status.pos_odd && status.hdr_final && status.hdr_err) begin
                  state_nxt = C_HDR_ERR;
                end
              end
              PH_ROWLEN: begin
                cmd.op = CMD_LEN;
              end
              PH_ROWDATA: begin
                cmd.op = CMD_DATA;
                if (!status.run_zero) begin
                  state_nxt = C_LEVEL;
                end else if (status.row_last_byte) begin
                  state_nxt = C_ROWEND;
                end
              end
              default: begin
                cmd.op = CMD_NONE;
              end
            endcase
          end
        end
      end
      C_HDR_ERR: begin
        if (status.slot_free) begin
          cmd.op    = CMD_HDR_ERR;
          state_nxt = C_IDLE;
        end
      end
      C_LEVEL: begin
        if (status.slot_free) begin
          cmd.op = CMD_LEVEL;
          if (status.run_last) begin
            state_nxt = status.row_done ? C_ROWEND : C_IDLE;
          end
        end
      end
      C_ROWEND: begin
        if (status.slot_free) begin
          cmd.op    = CMD_ROWEND;
          state_nxt = status.last_row ? C_DONE : C_IDLE;
        end
      end
      C_DONE: begin
        if (status.slot_free) begin
          cmd.op    = CMD_DONE;
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/raster_packet_rle_decoder_unit.sv -----
// channel  | signals                               | direction
// ---------+---------------------------------------+----------
// in       | in_valid, in_ready, in_data           | in
// out      | out_valid, out_ready, out_data        | out
// cfg      | cfg_valid, cfg_ready, cfg_index/data  | in
//
// one byte at a time: the byte is taken, then decoded, then one more step follows for each
// level, row end, packet done or header error it produces; the controller sequencer
// emits one result per cycle into the output register while that register has room.
// a full output register holds the sequencer; the next byte is taken once
// the last result of the current one is in the output register.
// reset clears the controller, the packet phase and the output valid, and loads the
// limit registers (464 rows, 920 bytes per row); cfg writes are always taken.
module raster_packet_rle_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rprle_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rprle_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rprle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rprle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rprle_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rprle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rprle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while the previous one is being decoded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != CMD_NONE) |-> status.slot_free)
    else $error("command issued while the output register is stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_DONE) |-> out_data.last)
    else $error("packet done not marked last");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_ERROR) |->
      (out_data.error_code != ERR_NONE && out_data.last))
    else $error("error item without code or last");
`endif

endmodule
